// File: sv/pftd_pkg.sv
`default_nettype none
package pftd_pkg;
	localparam int FACTOR_W = 32;
	localparam int EXP_W = 5;
	localparam int TOTAL_W = 6;
	localparam int DIST_W = 4;
	localparam int MAX_RESULTS = 9;

	typedef struct packed {
		logic [FACTOR_W-1:0] factor;
		logic [EXP_W-1:0] exponent;
		logic composite;
		logic [TOTAL_W-1:0] total_factors;
		logic [DIST_W-1:0] distinct_factors;
		logic last;
	} result_t;
endpackage
`default_nettype wire

// File: sv/pftd_divider.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module pftd_divider #(
	parameter int W = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [W-1:0] dividend,
	input wire logic [W-1:0] divisor,
	output logic done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);
	localparam int CW = $clog2(W + 1);
	logic busy_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0] quo_q, rem_q, dvs_q;
	logic [W:0] trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

// File: sv/pftd_front.sv
`default_nettype none
// Input queue: two entries between the port and the factoring engine.
module pftd_front #(
	parameter int W = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [W-1:0] number,
	output logic avail,
	output logic [W-1:0] head,
	input wire logic take
);
	logic [W-1:0] mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr;

	assign full = cnt_q == 2'd2;
	assign avail = cnt_q != 2'd0;
	assign head = mem_q[rp_q];
	assign wr = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (take) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, take};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= number;
	end
endmodule
`default_nettype wire

// File: sv/pftd_back.sv
`default_nettype none
// Trial division engine; one divide per candidate test.
module pftd_back #(
	parameter int W = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic avail,
	input wire logic [W-1:0] head,
	output logic take,
	output logic res_valid,
	output pftd_pkg::result_t res,
	input wire logic res_ready
);
	import pftd_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_WAIT = 3'd2;
	localparam logic [2:0] ST_DEC  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;
	localparam logic [2:0] ST_TAIL = 3'd5;

	logic [2:0] st_q;
	logic [W-1:0] num_q, rem_q, cand_q;
	logic [EXP_W-1:0] exp_q;
	logic [TOTAL_W-1:0] tot_q;
	logic [DIST_W-1:0] dist_q;
	logic found_q;
	// one result held back so the final one can be marked last
	logic pend_q;
	result_t pend_r_q;
	// results already sent for this number; the last slot is reused past the cap
	logic [3:0] sent_q;
	logic flush, emit_go;
	logic dstart, ddone;
	logic [W-1:0] quo, rmd;
	logic out_free;

	pftd_divider #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart),
		.dividend(rem_q), .divisor(cand_q),
		.done(ddone), .quotient(quo), .remainder(rmd)
	);

	assign dstart = st_q == ST_DIV;
	assign take = st_q == ST_IDLE && avail;
	assign out_free = !res_valid || res_ready;
	assign flush = pend_q && (sent_q != 4'(MAX_RESULTS - 1));
	assign emit_go = !flush || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			res_valid <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (res_valid && res_ready) res_valid <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (avail) begin
						pend_q <= 1'b0;
						// 0, 1 and 2 skip trial division
						st_q <= (head < W'(3)) ? ST_TAIL : ST_DIV;
					end
				end
				ST_DIV: st_q <= ST_WAIT;
				ST_WAIT: begin
					if (ddone) st_q <= ST_DEC;
				end
				ST_DEC: begin
					if (rmd == '0) begin
						st_q <= ST_DIV;
					end else if (quo < cand_q) begin
						// cand*cand > rem: done with candidates (after emitting)
						st_q <= found_q ? ST_EMIT : ST_TAIL;
					end else begin
						st_q <= found_q ? ST_EMIT : ST_DIV;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						if (flush) res_valid <= 1'b1;
						pend_q <= 1'b1;
						st_q <= (quo < cand_q) ? ST_TAIL : ST_DIV;
					end
				end
				ST_TAIL: begin
					if (out_free) begin
						if (pend_q && rem_q > W'(1) && rem_q != num_q) begin
							if (flush) res_valid <= 1'b1;
							pend_q <= 1'b1;
						end else begin
							res_valid <= 1'b1;
							pend_q <= 1'b0;
							st_q <= ST_IDLE;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				num_q <= head;
				rem_q <= head;
				cand_q <= W'(2);
				exp_q <= '0;
				tot_q <= '0;
				dist_q <= '0;
				found_q <= 1'b0;
				sent_q <= '0;
			end
			ST_DEC: begin
				if (rmd == '0) begin
					rem_q <= quo;
					exp_q <= exp_q + 1'b1;
					tot_q <= tot_q + 1'b1;
					if (!found_q) dist_q <= dist_q + 1'b1;
					found_q <= 1'b1;
				end else if (!found_q && !(quo < cand_q)) begin
					cand_q <= (cand_q == W'(2)) ? W'(3) : cand_q + W'(2);
				end
			end
			ST_EMIT: begin
				if (emit_go) begin
					if (flush) begin
						res <= pend_r_q;
						sent_q <= sent_q + 1'b1;
					end
					pend_r_q.factor <= FACTOR_W'(cand_q);
					pend_r_q.exponent <= exp_q;
					pend_r_q.composite <= 1'b1;
					pend_r_q.total_factors <= tot_q;
					pend_r_q.distinct_factors <= dist_q;
					pend_r_q.last <= 1'b0;
					exp_q <= '0;
					found_q <= 1'b0;
					cand_q <= (cand_q == W'(2)) ? W'(3) : cand_q + W'(2);
				end
			end
			ST_TAIL: begin
				if (out_free) begin
					if (pend_q && rem_q > W'(1) && rem_q != num_q) begin
						// leftover prime: flush held result, hold the leftover
						if (flush) begin
							res <= pend_r_q;
							sent_q <= sent_q + 1'b1;
						end
						pend_r_q.factor <= FACTOR_W'(rem_q);
						pend_r_q.exponent <= EXP_W'(1);
						pend_r_q.total_factors <= tot_q + 1'b1;
						pend_r_q.distinct_factors <= dist_q + 1'b1;
						tot_q <= tot_q + 1'b1;
						dist_q <= dist_q + 1'b1;
						rem_q <= W'(1);
					end else if (pend_q) begin
						res <= {pend_r_q[$bits(result_t)-1:1], 1'b1};
					end else begin
						res <= '{factor: '0, exponent: '0, composite: 1'b0,
							total_factors: '0, distinct_factors: '0, last: 1'b1};
					end
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// File: sv/prime_factorizer_trial_division_core.sv
`default_nettype none
// Sequence: each trial division passes ST_DIV, the bit-serial divider, ST_WAIT and ST_DEC, and
//   each prime found adds an ST_EMIT step; candidates run up to sqrt of the remainder, so a
//   large prime takes the longest.
// Throughput: one number at a time in the engine, set by the single bit-serial divider.
// A two-entry input queue accepts while the engine works; one result register on output.
// Reset: arst_n asynchronous active low clears queue pointers and engine state.
module prime_factorizer_trial_division_core #(
	parameter int NUMBER_WIDTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [NUMBER_WIDTH-1:0] number,
	output logic empty,
	input wire logic pop,
	output logic [31:0] factor,
	output logic [4:0] exponent,
	output logic composite,
	output logic [5:0] total_factors,
	output logic [3:0] distinct_factors,
	output logic last
);
	import pftd_pkg::*;

	logic avail, take, res_valid;
	logic [NUMBER_WIDTH-1:0] head;
	result_t res;

	pftd_front #(.W(NUMBER_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .number(number),
		.avail(avail), .head(head), .take(take)
	);

	pftd_back #(.W(NUMBER_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .avail(avail), .head(head), .take(take),
		.res_valid(res_valid), .res(res), .res_ready(pop)
	);

	assign empty = !res_valid;
	assign factor = res.factor;
	assign exponent = res.exponent;
	assign composite = res.composite;
	assign total_factors = res.total_factors;
	assign distinct_factors = res.distinct_factors;
	assign last = res.last;

`ifndef SYNTHESIS
	a_take_avail: assert property (@(posedge clk) disable iff (!arst_n) take |-> avail)
		else $error("engine took from empty queue");
	a_prime_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !composite) |-> (factor == '0 && last))
		else $error("non-composite result malformed");
	a_comp_fac: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && composite) |-> (factor > 32'd1 && exponent != '0))
		else $error("composite result without factor");
`endif
endmodule
`default_nettype wire
